### sv/wats_pkg.sv
// ----------------------------------------------------------------------------
// wats_pkg
// Types and constants shared by the weekday alarm table and its slot RAM.
// ----------------------------------------------------------------------------
package wats_pkg;

    localparam int MINUTES_PER_DAY = 24 * 60;
    localparam logic [10:0] NO_MINUTE = 11'd2047;

    // Command codes carried in the func field of an input item.
    typedef enum logic [2:0] {
        FUNC_WRITE   = 3'd0,
        FUNC_DELETE  = 3'd1,
        FUNC_TOGGLE  = 3'd2,
        FUNC_DISMISS = 3'd3,
        FUNC_SNOOZE  = 3'd4,
        FUNC_TICK    = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_RESP,
        ST_SCAN,
        ST_TICK_END
    } state_t;

    // One word of the slot RAM.
    typedef struct packed {
        logic [10:0] minute;
        logic [10:0] snooze_len;
        logic [6:0]  days;
        logic        enabled;
        logic [10:0] snooze_at;
    } slot_entry_t;

endpackage

### sv/wats_slot_ram.sv
// ----------------------------------------------------------------------------
// wats_slot_ram
// Single-port-write, single-port-read slot RAM with registered read data.
// ----------------------------------------------------------------------------
module wats_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  wats_pkg::slot_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output wats_pkg::slot_entry_t rd_data
);

    wats_pkg::slot_entry_t mem [DEPTH];
    wats_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data is held until the next read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/weekday_alarm_table_with_snooze_core.sv
// ----------------------------------------------------------------------------
// weekday_alarm_table_with_snooze_core
// Alarm slot table with weekday masks, snooze and a per-minute scan.
// ----------------------------------------------------------------------------
// The block keeps NUM_SLOTS alarm slots. Minute, snooze length, weekday mask,
// enable bit and snooze time live in a RAM with registered read data;
// the valid, playing and snoozed marks are flip-flops so that reset clears
// them at once. One item is worked on at a time. A command (write, delete,
// toggle, dismiss, snooze) reads its slot when it is accepted, updates it
// once the output register has room and returns one result item. A minute
// tick walks the RAM one slot per cycle, unless a hit must wait for room in
// the output register; a tick that repeats the last minute seen fires
// nothing and goes straight to its final result. A finished result sits in
// an output register, so the next item is accepted while the previous
// result still waits to be taken. Fired slots come out in slot order; only
// the final result of an item has tlast set, and a tick that fires nothing
// still returns one result.
module weekday_alarm_table_with_snooze_core #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata, from bit 0: func[2:0], slot[3:0], alarm_minute[10:0],
    // snooze_len[10:0], day_mask[6:0], enable_in, now_minute[10:0],
    // weekday[2:0], then zero padding.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // m_tdata, from bit 0: fired_slot[3:0], fired, status, then zero padding.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);
    localparam logic [11:0] DAY_1 = 12'(wats_pkg::MINUTES_PER_DAY);
    localparam logic [11:0] DAY_2 = 12'(2 * wats_pkg::MINUTES_PER_DAY);

    // Input unpacking.
    wats_pkg::func_t in_func;
    logic [3:0]      in_slot;
    logic [6:0]      in_slot_wide;
    logic            in_in_table;
    logic [10:0]     in_now;

    assign in_func      = wats_pkg::func_t'(s_tdata[2:0]);
    assign in_slot      = s_tdata[6:3];
    assign in_now       = s_tdata[47:37];
    assign in_slot_wide = 7'(in_slot);
    assign in_in_table  = (in_slot_wide < 7'(NUM_SLOTS));

    // Control and status registers.
    wats_pkg::state_t     state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [3:0]           pend_slot_reg, pend_slot_next;
    logic [10:0]          last_minute_reg, last_minute_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] playing_reg, playing_next;
    logic [NUM_SLOTS-1:0] snoozed_reg, snoozed_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // Captured item and output payload.
    wats_pkg::func_t func_reg;
    logic [3:0]      slot_reg;
    logic [10:0]     amin_reg;
    logic [10:0]     slen_reg;
    logic [6:0]      mask_reg;
    logic            en_reg;
    logic [10:0]     now_reg;
    logic [2:0]      wday_reg;
    logic [5:0]      m_data_reg, m_data_next;
    logic            m_tlast_reg, m_tlast_next;

    // RAM ports.
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    wats_pkg::slot_entry_t rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    wats_pkg::slot_entry_t wr_data;

    logic          accept;
    logic          out_free;
    logic [AW-1:0] cmd_addr;
    logic [6:0]    wday_bit;
    logic          alarm_hit;
    logic          snooze_hit;
    logic          hit;
    logic [11:0]   snz_sum;
    logic [10:0]   snz_at;

    assign s_tready = (state_reg == wats_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cmd_addr = AW'(7'(slot_reg));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_data_reg};
    assign m_tlast  = m_tlast_reg;

    // The weekday has no mask bit when it is seven, so no alarm can match.
    assign wday_bit   = (wday_reg < 3'd7) ? (7'd1 << wday_reg) : 7'd0;
    assign alarm_hit  = valid_reg[idx_reg] && rd_data.enabled &&
                        (rd_data.minute == now_reg) &&
                        ((rd_data.days & wday_bit) != 7'd0) &&
                        !playing_reg[idx_reg];
    assign snooze_hit = valid_reg[idx_reg] && snoozed_reg[idx_reg] &&
                        (rd_data.snooze_at == now_reg);
    assign hit        = alarm_hit || snooze_hit;

    // Snooze time is (now + length) mod one day; the sum stays below three days.
    assign snz_sum = 12'(now_reg) + 12'(rd_data.snooze_len);
    always_comb begin
        if (snz_sum >= DAY_2) begin
            snz_at = 11'(snz_sum - DAY_2);
        end else if (snz_sum >= DAY_1) begin
            snz_at = 11'(snz_sum - DAY_1);
        end else begin
            snz_at = snz_sum[10:0];
        end
    end

    wats_slot_ram #(
        .DEPTH (NUM_SLOTS),
        .AW    (AW)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        last_minute_next = last_minute_reg;
        valid_next       = valid_reg;
        playing_next     = playing_reg;
        snoozed_next     = snoozed_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_tlast_next     = m_tlast_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg;
        wr_en            = 1'b0;
        wr_addr          = cmd_addr;
        wr_data          = rd_data;

        unique case (state_reg)
            wats_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_func == wats_pkg::FUNC_TICK) begin
                        pend_valid_next = 1'b0;
                        if (in_now == last_minute_reg) begin
                            state_next = wats_pkg::ST_TICK_END;
                        end else begin
                            last_minute_next = in_now;
                            idx_next         = '0;
                            rd_en            = 1'b1;
                            rd_addr          = '0;
                            state_next       = wats_pkg::ST_SCAN;
                        end
                    end else if (in_func > wats_pkg::FUNC_TICK || !in_in_table) begin
                        state_next = wats_pkg::ST_RESP;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(in_slot_wide);
                        state_next = wats_pkg::ST_CMD;
                    end
                end
            end

            wats_pkg::ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {1'b1, 1'b0, slot_reg};
                    m_tlast_next  = 1'b1;
                    state_next    = wats_pkg::ST_IDLE;
                end
            end

            wats_pkg::ST_CMD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    state_next    = wats_pkg::ST_IDLE;
                    if (func_reg == wats_pkg::FUNC_WRITE) begin
                        wr_en                  = 1'b1;
                        wr_data.minute         = amin_reg;
                        wr_data.snooze_len     = slen_reg;
                        wr_data.days           = mask_reg;
                        wr_data.enabled        = en_reg;
                        valid_next[cmd_addr]   = 1'b1;
                        playing_next[cmd_addr] = 1'b0;
                        snoozed_next[cmd_addr] = 1'b0;
                        m_data_next            = {1'b0, 1'b0, slot_reg};
                    end else if (!valid_reg[cmd_addr]) begin
                        // Empty slot: nothing changes.
                        m_data_next = {1'b1, 1'b0, slot_reg};
                    end else begin
                        m_data_next = {1'b0, 1'b0, slot_reg};
                        unique case (func_reg)
                            wats_pkg::FUNC_DELETE: begin
                                valid_next[cmd_addr]   = 1'b0;
                                playing_next[cmd_addr] = 1'b0;
                                snoozed_next[cmd_addr] = 1'b0;
                            end
                            wats_pkg::FUNC_TOGGLE: begin
                                wr_en           = 1'b1;
                                wr_data.enabled = !rd_data.enabled;
                            end
                            wats_pkg::FUNC_DISMISS: begin
                                playing_next[cmd_addr] = 1'b0;
                                snoozed_next[cmd_addr] = 1'b0;
                            end
                            default: begin
                                wr_en                  = 1'b1;
                                wr_data.snooze_at      = snz_at;
                                playing_next[cmd_addr] = 1'b0;
                                snoozed_next[cmd_addr] = 1'b1;
                            end
                        endcase
                    end
                end
            end

            wats_pkg::ST_SCAN: begin
                // A hit with a result already pending must wait for room
                // in the output register before it can replace it.
                if (!(hit && pend_valid_reg && !out_free)) begin
                    if (hit) begin
                        playing_next[idx_reg] = 1'b1;
                        if (snooze_hit) begin
                            snoozed_next[idx_reg] = 1'b0;
                        end
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_data_next   = {1'b0, 1'b1, pend_slot_reg};
                            m_tlast_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = 4'(idx_reg);
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = wats_pkg::ST_TICK_END;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end

            wats_pkg::ST_TICK_END: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_data_next = {1'b0, 1'b1, pend_slot_reg};
                    end else begin
                        m_data_next = 6'd0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = wats_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = wats_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= wats_pkg::ST_IDLE;
            idx_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            last_minute_reg <= wats_pkg::NO_MINUTE;
            valid_reg       <= '0;
            playing_reg     <= '0;
            snoozed_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            pend_valid_reg  <= pend_valid_next;
            last_minute_reg <= last_minute_next;
            valid_reg       <= valid_next;
            playing_reg     <= playing_next;
            snoozed_reg     <= snoozed_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_slot_reg <= pend_slot_next;
        m_data_reg    <= m_data_next;
        m_tlast_reg   <= m_tlast_next;
        if (accept) begin
            func_reg <= in_func;
            slot_reg <= in_slot;
            amin_reg <= s_tdata[17:7];
            slen_reg <= s_tdata[28:18];
            mask_reg <= s_tdata[35:29];
            en_reg   <= s_tdata[36];
            now_reg  <= in_now;
            wday_reg <= s_tdata[50:48];
        end
    end

endmodule

### tb/sv/weekday_alarm_table_with_snooze_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weekday_alarm_table_with_snooze_core_tb
// Self-checking testbench for the weekday alarm table with snooze.
// ----------------------------------------------------------------------------
// A tracker class keeps its own copy of the slot table and the last minute
// seen. For every item accepted on the input stream it predicts the result
// items: one per command, and one per fired slot (or a single empty result)
// for a minute tick. Results taken from the output stream are compared with
// the oldest prediction. A short directed sequence covers the corner cases;
// after it come random commands aimed at a few busy minutes so that alarms
// and snoozes really fire. The sender idles in bursts, the receiver stalls
// on a pattern of its own, and once it holds off long enough to back up
// the block's input.
// ----------------------------------------------------------------------------
module weekday_alarm_table_with_snooze_core_tb;

    localparam int NUM_SLOTS   = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SQUEEZE_LEN = 400;

    // Func codes the block does not know; they must come back with status 1.
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    // Input item, laid out so that it drops straight into s_tdata.
    typedef struct packed {
        logic [2:0]  weekday;
        logic [10:0] now_minute;
        logic        enable_in;
        logic [6:0]  day_mask;
        logic [10:0] snooze_len;
        logic [10:0] alarm_minute;
        logic [3:0]  slot;
        logic [2:0]  func;
    } alarm_cmd_t;

    typedef struct packed {
        logic [3:0] fired_slot;
        logic       fired;
        logic       status;
        logic       last_flag;
    } alarm_report_t;

    // Keeps a shadow of the slot table and the queue of reports it implies.
    class alarm_slot_tracker;
        bit            valid     [NUM_SLOTS];
        logic [10:0]   minute    [NUM_SLOTS];
        logic [10:0]   snooze_len[NUM_SLOTS];
        logic [6:0]    days      [NUM_SLOTS];
        bit            enabled   [NUM_SLOTS];
        bit            playing   [NUM_SLOTS];
        bit            snoozed   [NUM_SLOTS];
        logic [10:0]   snooze_at [NUM_SLOTS];
        logic [10:0]   last_minute;
        alarm_report_t due_reports[$];
        int            errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                valid[i]   = 1'b0;
                playing[i] = 1'b0;
                snoozed[i] = 1'b0;
            end
            last_minute = wats_pkg::NO_MINUTE;
            errors      = 0;
        endfunction

        task flag_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void push_report(int s, bit f, bit st, bit l);
            alarm_report_t r;
            r.fired_slot = 4'(s);
            r.fired      = f;
            r.status     = st;
            r.last_flag  = l;
            due_reports.push_back(r);
        endfunction

        function int outstanding();
            return due_reports.size();
        endfunction

        // Called once per item accepted on the input stream.
        function void note_command(alarm_cmd_t c);
            bit [NUM_SLOTS-1:0] hits;
            int                 n_hits;
            int                 seen;
            logic [6:0]         day_bit;
            bit                 st;
            int                 i;
            if (c.func == wats_pkg::FUNC_TICK) begin
                hits    = '0;
                day_bit = (c.weekday < 3'd7) ? 7'(1 << c.weekday) : 7'd0;
                // A tick repeating the last minute fires nothing.
                if (c.now_minute != last_minute) begin
                    last_minute = c.now_minute;
                    for (i = 0; i < NUM_SLOTS; i++) begin
                        if (valid[i] && enabled[i] && minute[i] == c.now_minute &&
                            (days[i] & day_bit) != 7'd0 && !playing[i])
                            hits[i] = 1'b1;
                        if (valid[i] && snoozed[i] && snooze_at[i] == c.now_minute) begin
                            snoozed[i] = 1'b0;
                            hits[i]    = 1'b1;
                        end
                        if (hits[i])
                            playing[i] = 1'b1;
                    end
                end
                if (hits == '0) begin
                    push_report(0, 1'b0, 1'b0, 1'b1);
                end else begin
                    n_hits = $countones(hits);
                    seen   = 0;
                    for (i = 0; i < NUM_SLOTS; i++) begin
                        if (hits[i]) begin
                            seen++;
                            push_report(i, 1'b1, 1'b0, seen == n_hits);
                        end
                    end
                end
            end else begin
                st = 1'b0;
                i  = int'(c.slot);
                if (c.func == FUNC_RSVD6 || c.func == FUNC_RSVD7) begin
                    st = 1'b1;
                end else if (c.func == wats_pkg::FUNC_WRITE) begin
                    valid[i]      = 1'b1;
                    minute[i]     = c.alarm_minute;
                    snooze_len[i] = c.snooze_len;
                    days[i]       = c.day_mask;
                    enabled[i]    = c.enable_in;
                    playing[i]    = 1'b0;
                    snoozed[i]    = 1'b0;
                end else if (!valid[i]) begin
                    st = 1'b1;
                end else if (c.func == wats_pkg::FUNC_DELETE) begin
                    valid[i]   = 1'b0;
                    playing[i] = 1'b0;
                    snoozed[i] = 1'b0;
                end else if (c.func == wats_pkg::FUNC_TOGGLE) begin
                    enabled[i] = !enabled[i];
                end else if (c.func == wats_pkg::FUNC_DISMISS) begin
                    playing[i] = 1'b0;
                    snoozed[i] = 1'b0;
                end else begin
                    playing[i]   = 1'b0;
                    snoozed[i]   = 1'b1;
                    snooze_at[i] = 11'((int'(c.now_minute) + int'(snooze_len[i]))
                                       % wats_pkg::MINUTES_PER_DAY);
                end
                push_report(int'(c.slot), 1'b0, st, 1'b1);
            end
        endfunction

        // Called once per item taken from the output stream.
        task check_report(alarm_report_t got);
            alarm_report_t want;
            if (due_reports.size() == 0) begin
                flag_mismatch($sformatf(
                    "unexpected result slot %0d fired %0b status %0b last %0b",
                    got.fired_slot, got.fired, got.status, got.last_flag));
            end else begin
                want = due_reports.pop_front();
                if (got.fired_slot !== want.fired_slot || got.fired !== want.fired ||
                    got.status !== want.status || got.last_flag !== want.last_flag)
                    flag_mismatch($sformatf(
                        "got slot %0d fired %0b status %0b last %0b, want %0d %0b %0b %0b",
                        got.fired_slot, got.fired, got.status, got.last_flag,
                        want.fired_slot, want.fired, want.status, want.last_flag));
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    alarm_slot_tracker tracker;
    int                idle_cycles = 0;
    int                burst_left  = 0;
    bit                squeeze_req = 1'b0;
    int                hot_min[4];

    weekday_alarm_table_with_snooze_core #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic alarm_cmd_t mk_cmd(logic [2:0] f, int s, int am, int sl, int dm,
                                          int en, int nm, int wd);
        alarm_cmd_t c;
        c.func         = f;
        c.slot         = 4'(s);
        c.alarm_minute = 11'(am);
        c.snooze_len   = 11'(sl);
        c.day_mask     = 7'(dm);
        c.enable_in    = 1'(en);
        c.now_minute   = 11'(nm);
        c.weekday      = 3'(wd);
        return c;
    endfunction

    // Random command. Minutes mostly come from a small pool of busy minutes
    // and snooze lengths are mostly short, so ticks keep hitting live slots.
    function automatic alarm_cmd_t random_cmd();
        alarm_cmd_t c;
        int         pick;
        c    = alarm_cmd_t'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            c.func         = wats_pkg::FUNC_WRITE;
            c.alarm_minute = ($urandom_range(0, 9) != 0) ? 11'(hot_min[$urandom_range(0, 3)])
                                                         : 11'($urandom_range(0, 2047));
            c.snooze_len   = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(0, 3))
                                                        : 11'($urandom_range(0, 2047));
            c.day_mask     = ($urandom_range(0, 1) == 0) ? 7'h7f : 7'($urandom);
            c.enable_in    = ($urandom_range(0, 4) != 0);
        end else if (pick < 24) begin
            c.func = wats_pkg::FUNC_DELETE;
        end else if (pick < 32) begin
            c.func = wats_pkg::FUNC_TOGGLE;
        end else if (pick < 40) begin
            c.func = wats_pkg::FUNC_DISMISS;
        end else if (pick < 52) begin
            c.func       = wats_pkg::FUNC_SNOOZE;
            c.now_minute = ($urandom_range(0, 4) != 0) ? 11'(hot_min[$urandom_range(0, 3)])
                                                       : 11'($urandom_range(0, 2047));
        end else if (pick < 97) begin
            c.func       = wats_pkg::FUNC_TICK;
            c.now_minute = ($urandom_range(0, 6) != 0)
                         ? 11'(hot_min[$urandom_range(0, 3)] + $urandom_range(0, 4))
                         : 11'($urandom_range(0, 2047));
            c.weekday    = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, 6)) : 3'd7;
        end else begin
            c.func = ($urandom_range(0, 1) == 0) ? FUNC_RSVD6 : FUNC_RSVD7;
        end
        return c;
    endfunction

    // Offers one item and returns at the falling edge after it is taken.
    // Between bursts of random length the sender may idle for a while.
    task automatic send_cmd(input alarm_cmd_t c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        s_tdata  <= {5'b0, c};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(c);
        @(negedge aclk);
    endtask

    // Receiver: a 16-bit ready pattern that is redrawn now and then, with
    // one long hold-off when the sender asks for it.
    initial begin
        int          phase;
        int          hold;
        logic [15:0] pattern;
        phase   = 0;
        hold    = 0;
        pattern = '1;
        forever begin
            @(negedge aclk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold        = SQUEEZE_LEN;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                if (phase % 48 == 0)
                    pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h1);
                m_tready <= pattern[phase % 16];
                phase++;
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_report({m_tdata[3:0], m_tdata[4], m_tdata[5], m_tlast});
    end

    // Watchdog: ends the run if neither stream moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        alarm_cmd_t directed[$];
        alarm_cmd_t c;
        int         busy_minute;
        tracker = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // First tick at the reset value of the last minute is ignored.
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 2047, 0));
        // Commands on an empty slot change nothing and report status 1.
        directed.push_back(mk_cmd(wats_pkg::FUNC_DELETE, 3, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_TOGGLE, 3, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_DISMISS, 3, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_SNOOZE, 3, 0, 0, 0, 0, 10, 0));
        // Unknown func codes.
        directed.push_back(mk_cmd(FUNC_RSVD6, 9, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_cmd(FUNC_RSVD7, 15, 2047, 2047, 127, 1, 2047, 7));
        // Two slots on the same minute; slot 15 only rings on weekday 0.
        directed.push_back(mk_cmd(wats_pkg::FUNC_WRITE, 0, 100, 5, 127, 1, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_WRITE, 15, 100, 1439, 1, 1, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 100, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 100, 0));
        // Snooze sums that wrap past midnight.
        directed.push_back(mk_cmd(wats_pkg::FUNC_SNOOZE, 0, 0, 0, 0, 0, 1438, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_SNOOZE, 15, 0, 0, 0, 0, 1439, 0));
        // Weekday seven: only the snooze of slot 0 may fire.
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 3, 7));
        directed.push_back(mk_cmd(wats_pkg::FUNC_DISMISS, 0, 0, 0, 0, 0, 0, 0));
        // A disabled slot still wakes up from its snooze.
        directed.push_back(mk_cmd(wats_pkg::FUNC_TOGGLE, 15, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_SNOOZE, 15, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 1439, 6));
        // Minutes beyond the day are compared as given.
        directed.push_back(mk_cmd(wats_pkg::FUNC_WRITE, 7, 2047, 2047, 127, 1, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 2047, 3));
        directed.push_back(mk_cmd(wats_pkg::FUNC_SNOOZE, 7, 0, 0, 0, 0, 2047, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_DELETE, 7, 0, 0, 0, 0, 0, 0));
        // A slot matching by alarm and by snooze on the same tick fires once.
        directed.push_back(mk_cmd(wats_pkg::FUNC_WRITE, 4, 50, 10, 127, 1, 0, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 50, 2));
        directed.push_back(mk_cmd(wats_pkg::FUNC_SNOOZE, 4, 0, 0, 0, 0, 40, 0));
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 49, 2));
        directed.push_back(mk_cmd(wats_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 50, 2));
        foreach (directed[i])
            send_cmd(directed[i]);

        // Random part. It opens with every slot set to one minute and a tick
        // on that minute, while the receiver holds off for a long stretch.
        for (int i = 0; i < 4; i++)
            hot_min[i] = $urandom_range(0, 1435);
        busy_minute = $urandom_range(0, 1000);
        squeeze_req = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++)
            send_cmd(mk_cmd(wats_pkg::FUNC_WRITE, s, busy_minute, $urandom_range(0, 3), 127, 1,
                            $urandom_range(0, 2047), $urandom_range(0, 7)));
        send_cmd(mk_cmd(wats_pkg::FUNC_TICK, $urandom_range(0, 15), $urandom_range(0, 2047),
                        $urandom_range(0, 2047), $urandom_range(0, 127), $urandom_range(0, 1),
                        busy_minute, $urandom_range(0, 6)));
        for (int n = 0; n < 56; n++) begin
            c = random_cmd();
            send_cmd(c);
        end
        s_tvalid <= 1'b0;

        while (tracker.outstanding() != 0)
            @(posedge aclk);
        // Room for any stray result a full slot scan could still produce.
        repeat (2 * NUM_SLOTS + 10) @(posedge aclk);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
sv/wats_pkg.sv
sv/wats_slot_ram.sv
sv/weekday_alarm_table_with_snooze_core.sv
tb/sv/weekday_alarm_table_with_snooze_core_tb.sv
